// ===== hw/rtl/spi_msp_pkg.sv =====
// Shared types, register bit positions and helper functions for the SPI port.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package spi_msp_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_DATA    = 2'd0,
    SEL_STATUS  = 2'd1,
    SEL_CONTROL = 2'd2
  } sel_t;

  // Control register bits.
  localparam int CTL_SPIE = 7;
  localparam int CTL_SPE  = 6;
  localparam int CTL_DORD = 5;
  localparam int CTL_MSTR = 4;
  localparam int CTL_CPOL = 3;
  localparam int CTL_CPHA = 2;

  // Status register bits.
  localparam int STA_SPIF = 7;
  localparam int STA_WCOL = 6;
  localparam int STA_2X   = 0;

  localparam logic [3:0] BIT_IDLE = 4'd8;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
    logic       miso_in;
    logic       mosi_in;
    logic       sck_in;
    logic       ss_in;
    logic       ss_is_output;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       mosi_out;
    logic       miso_out;
    logic       sck_out;
    logic       irq_request;
    logic       master_mode;
  } out_item_t;

  typedef struct packed {
    logic [7:0] control;
    logic [7:0] status;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [7:0] shift;
    logic [3:0] bit_count;
    logic [6:0] tick_count;
    logic [6:0] divider;
    logic       done;
    logic       status_read;
    logic       prev_clock;
    logic       mosi_drive;
    logic       miso_drive;
    logic       sck_drive;
  } spi_state_t;

  // Half period of the shift clock in ticks; always a power of two.
  function automatic logic [6:0] calc_divider(input logic [1:0] spr, input logic x2);
    logic [6:0] d;
    case (spr)
      2'd0:    d = 7'd1;
      2'd1:    d = 7'd4;
      2'd2:    d = 7'd16;
      default: d = 7'd32;
    endcase
    return x2 ? d : {d[5:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spi_msp_if.sv =====
// Valid/ready channel interfaces for requests into and results out of the SPI port.
// Depends on spi_msp_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface spi_msp_in_if;
  import spi_msp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spi_msp_out_if;
  import spi_msp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spi_msp_core.sv =====
// Register file, shift engine and state update of the SPI port, one request per enable.
// Depends on spi_msp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spi_msp_core (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire                     cfg_wdata,
  input  wire                     step_en,
  input  spi_msp_pkg::in_item_t   item,
  output spi_msp_pkg::out_item_t  result
);
  import spi_msp_pkg::*;

  spi_state_t state_r, state_nxt;
  logic       x2_wr_en_r;

  function automatic spi_state_t write_control(input spi_state_t s, input logic [7:0] v);
    s.control = v;
    if (v[CTL_SPE]) begin
      if (v[CTL_MSTR]) begin
        s.mosi_drive = 1'b1;
        s.sck_drive  = v[CTL_CPOL];
      end
    end else begin
      s.bit_count = BIT_IDLE;
      s.done      = 1'b0;
    end
    s.divider = calc_divider(v[1:0], s.status[STA_2X]);
    return s;
  endfunction

  function automatic spi_state_t tx_bit(input spi_state_t s, input logic [2:0] p);
    if (s.control[CTL_MSTR]) begin
      s.mosi_drive = s.tx_byte[p];
    end else begin
      s.miso_drive = s.tx_byte[p];
    end
    return s;
  endfunction

  function automatic spi_state_t rx_bit(input spi_state_t s, input logic [2:0] p,
                                        input logic miso, input logic mosi);
    if (s.control[CTL_MSTR] ? miso : mosi) begin
      s.shift[p] = 1'b1;
    end
    return s;
  endfunction

  always_comb begin : step
    spi_state_t s;
    logic       irq;
    logic [7:0] rd;
    logic [2:0] pos;
    logic [2:0] prev_pos;
    logic       cpol;
    logic       cpha;
    logic       leading;
    s        = state_r;
    irq      = 1'b0;
    rd       = 8'd0;
    leading  = 1'b0;
    cpol     = s.control[CTL_CPOL];
    cpha     = s.control[CTL_CPHA];
    pos      = s.control[CTL_DORD] ? s.bit_count[2:0] : ~s.bit_count[2:0];
    prev_pos = s.control[CTL_DORD] ? (s.bit_count[2:0] - 3'd1) : (3'd0 - s.bit_count[2:0]);
    unique case (cmd_t'(item.cmd))
      CMD_TICK: begin
        if (s.control[CTL_SPE]) begin
          if (s.control[CTL_MSTR]) begin
            if (!item.ss_is_output && !item.ss_in) begin
              s = write_control(s, s.control & ~(8'd1 << CTL_MSTR));
              s.status[STA_SPIF] = 1'b1;
              irq = irq | s.control[CTL_SPIE];
              s.bit_count  = BIT_IDLE;
              s.done       = 1'b0;
              s.tick_count = 7'd0;
            end
            if ((s.tick_count & (s.divider - 7'd1)) == 7'd0) begin
              if (s.bit_count < BIT_IDLE) begin
                if (s.bit_count == 4'd0) begin
                  s.shift = 8'd0;
                end
                if ((s.tick_count & s.divider) == 7'd0) begin
                  s.sck_drive = cpol;
                  if (cpha) begin
                    if (s.bit_count != 4'd0) begin
                      s = rx_bit(s, prev_pos, item.miso_in, item.mosi_in);
                    end
                  end else begin
                    s = tx_bit(s, pos);
                  end
                end else begin
                  s.sck_drive = !cpol;
                  if (cpha) begin
                    s = tx_bit(s, pos);
                  end else begin
                    s = rx_bit(s, pos, item.miso_in, item.mosi_in);
                  end
                  s.bit_count = s.bit_count + 4'd1;
                end
                s.done = (s.bit_count == BIT_IDLE);
              end else if (s.done) begin
                if (cpha) begin
                  s = rx_bit(s, prev_pos, item.miso_in, item.mosi_in);
                end
                s.done    = 1'b0;
                s.tx_byte = s.shift;
                s.rx_byte = s.shift;
                s.status[STA_SPIF] = 1'b1;
                irq = irq | s.control[CTL_SPIE];
                s.status_read = 1'b0;
                s.sck_drive   = cpol;
                if (!cpha) begin
                  s.mosi_drive = 1'b1;
                end
              end
            end
          end else if (item.ss_in) begin
            s.bit_count = BIT_IDLE;
          end else begin
            if (s.bit_count >= BIT_IDLE) begin
              s.bit_count  = 4'd0;
              s.done       = 1'b0;
              s.shift      = 8'd0;
              s.prev_clock = item.sck_in;
            end else if (!cpha) begin
              s = tx_bit(s, pos);
            end
            if (item.sck_in != s.prev_clock) begin
              leading = cpol ? !item.sck_in : item.sck_in;
              if (leading ^ cpha) begin
                s = rx_bit(s, pos, item.miso_in, item.mosi_in);
              end else begin
                s = tx_bit(s, pos);
              end
              if (!leading) begin
                s.bit_count = s.bit_count + 4'd1;
                s.done      = (s.bit_count == BIT_IDLE);
              end
            end
            if (s.done) begin
              s.done    = 1'b0;
              s.tx_byte = s.shift;
              s.rx_byte = s.shift;
              s.status[STA_SPIF] = 1'b1;
              irq = irq | s.control[CTL_SPIE];
              s.status_read = 1'b0;
            end
            s.prev_clock = item.sck_in;
          end
          s.tick_count = s.tick_count + 7'd1;
        end
      end
      CMD_READ: begin
        unique case (item.reg_sel)
          SEL_DATA: begin
            if (s.status_read) begin
              s.status[STA_SPIF] = 1'b0;
              s.status[STA_WCOL] = 1'b0;
              s.status_read      = 1'b0;
            end
            rd = s.rx_byte;
          end
          SEL_STATUS: begin
            s.status_read = 1'b1;
            rd = s.status;
          end
          SEL_CONTROL: rd = s.control;
          default: rd = 8'd0;
        endcase
      end
      CMD_WRITE: begin
        unique case (item.reg_sel)
          SEL_DATA: begin
            if (s.status_read) begin
              s.status[STA_SPIF] = 1'b0;
              s.status[STA_WCOL] = 1'b0;
              s.status_read      = 1'b0;
            end
            s.tx_byte = item.write_data;
            if (s.control[CTL_MSTR]) begin
              if (s.bit_count < BIT_IDLE) begin
                s.status[STA_WCOL] = 1'b1;
              end else begin
                s.bit_count  = 4'd0;
                s.done       = 1'b0;
                s.tick_count = 7'd0;
              end
            end
          end
          SEL_STATUS: begin
            if (x2_wr_en_r) begin
              s.status[STA_2X] = item.write_data[STA_2X];
              s.divider = calc_divider(s.control[1:0], s.status[STA_2X]);
            end
          end
          SEL_CONTROL: s = write_control(s, item.write_data);
          default: ;
        endcase
      end
      CMD_ACK: s.status[STA_SPIF] = 1'b0;
      default: ;
    endcase
    state_nxt          = s;
    result.read_data   = rd;
    result.mosi_out    = s.mosi_drive;
    result.miso_out    = s.miso_drive;
    result.sck_out     = s.sck_drive;
    result.irq_request = irq;
    result.master_mode = s.control[CTL_MSTR];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.control     <= 8'd0;
      state_r.status      <= 8'd0;
      state_r.tx_byte     <= 8'd0;
      state_r.rx_byte     <= 8'd0;
      state_r.shift       <= 8'd0;
      state_r.bit_count   <= BIT_IDLE;
      state_r.tick_count  <= 7'd0;
      state_r.divider     <= calc_divider(2'd0, 1'b0);
      state_r.done        <= 1'b0;
      state_r.status_read <= 1'b0;
      state_r.prev_clock  <= 1'b0;
      state_r.mosi_drive  <= 1'b1;
      state_r.miso_drive  <= 1'b0;
      state_r.sck_drive   <= 1'b0;
      x2_wr_en_r          <= 1'b1;
    end else begin
      if (step_en) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        x2_wr_en_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spi_master_slave_port.sv =====
// Top level of the SPI port: request register, core and result register.
// Depends on spi_msp_pkg, spi_msp_if and spi_msp_core.
//
//   Channel   Direction  Carries
//   in_if     sink       tick, register read, register write or acknowledge
//   out_if    source     read byte, pin drives, interrupt and master bit
//   cfg_we    write      double-speed write enable (cfg_wdata)
//
// A request waits in the request register and is processed as it moves into the
// result register, from which its result is offered.
// One request per cycle while results drain; the state update is a single pass.
// Reset is synchronous; it clears both pipeline full flags and the port state.
// When the result is not taken, the result register holds, and once the request
// register is also full, in_if.ready falls.
`timescale 1ns / 1ps
`default_nettype none

module spi_master_slave_port (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  spi_msp_in_if.sink           in_if,
  spi_msp_out_if.source        out_if
);
  import spi_msp_pkg::*;

  logic      in_full_r, in_full_nxt;
  in_item_t  in_item_r;
  logic      out_full_r, out_full_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;
  logic      in_take;

  assign advance      = !out_full_r || out_if.ready;
  assign in_if.ready  = !in_full_r || advance;
  assign in_take      = in_if.valid && in_if.ready;
  assign in_full_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_full_r);
  assign out_full_nxt = advance ? in_full_r : out_full_r;

  spi_msp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (in_full_r && advance),
    .item      (in_item_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r  <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      in_full_r  <= in_full_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_if.data;
    end
    if (advance && in_full_r) begin
      out_item_r <= result;
    end
  end

  assign out_if.valid = out_full_r;
  assign out_if.data  = out_item_r;

endmodule

`default_nettype wire
